// ----- rtl/qeit_pkg.sv -----
package qeit_pkg;

  typedef enum logic [1:0] {
    MODE_A_EDGE = 2'd0,
    MODE_B_EDGE = 2'd1,
    MODE_INDEX  = 2'd2,
    MODE_TICK   = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  a_level;
    logic  b_level;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] position_count;
    logic        [31:0] turn_count;
    logic        [30:0] counts_per_rev;
    logic signed [31:0] angle_q16;
    logic        [30:0] speed_q16;
  } out_item_t;

  // configuration register map
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_INDEX_THRESHOLD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE     = 1'd1;

  localparam logic [15:0] THRESHOLD_RESET   = 16'd200;
  localparam logic [15:0] SAMPLE_RATE_RESET = 16'd100;
  localparam logic [30:0] REV_COUNTS_RESET  = 31'd200;

  // 2*pi in Q3.28
  localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;
  localparam logic [30:0] POS_MAX    = 31'h7FFF_FFFF;

  localparam int DIFF_W      = 33;
  localparam int SPEED_ACC_W = DIFF_W + 16;

endpackage

// ----- rtl/quadrature_encoder_index_tracker.sv -----
// an accepted beat runs through prep, the bit-serial 2*pi multiplier, an overflow check,
//   the restoring divider (one bit a cycle, skipped on overflow) and the angle step, then
//   the delta and speed steps for a tick; zero counts per revolution skips the angle math
// throughput: one item at a time, the next beat is taken the cycle after the result is loaded
// reset: synchronous, active high; counters, calibration, config and the output register return
//   to their reset values and any item in flight is dropped
module quadrature_encoder_index_tracker
  import qeit_pkg::*;
#(
  parameter int COUNT_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data
);

  localparam int W     = COUNT_WIDTH;
  localparam int S     = 28 - FRAC_BITS;
  localparam int K     = 31 + S;
  localparam int PW    = W + 31;
  localparam int DW    = K + 31;
  localparam int XW    = (PW > DW) ? PW : DW;
  localparam int EW    = (W > 31) ? W : 31;
  localparam int CNT_W = $clog2(K);
  localparam logic [K:0] ROUND_HALF = (K + 1)'(1) << (S - 1);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_PREP = 10'b00_0000_0010,
    ST_MUL  = 10'b00_0000_0100,
    ST_CHK  = 10'b00_0000_1000,
    ST_DIV  = 10'b00_0001_0000,
    ST_ANG  = 10'b00_0010_0000,
    ST_DLT  = 10'b00_0100_0000,
    ST_SPD  = 10'b00_1000_0000,
    ST_SAT  = 10'b01_0000_0000,
    ST_FIN  = 10'b10_0000_0000
  } state_t;

  state_t state;

  logic [W-1:0]  count;
  logic [31:0]   turns;
  logic [30:0]   rev_counts;
  logic [31:0]   prev_angle;
  logic [30:0]   speed_magnitude;
  logic [15:0]   index_threshold;
  logic [15:0]   sample_rate_hz;

  logic                   tick;
  logic [W-1:0]           mag;
  logic                   neg;
  logic                   sat;
  logic [XW-1:0]          prod;
  logic [30:0]            rem;
  logic [K-1:0]           dvd;
  logic [31:0]            angle_reg;
  logic [DIFF_W-1:0]      dm;
  logic [SPEED_ACC_W-1:0] acc;
  logic [CNT_W-1:0]       cnt;

  logic                   in_accept;
  logic [W-1:0]           mag_abs;
  logic [EW-1:0]          mag_ext;
  logic                   index_hit;
  logic [30:0]            rev_new;
  logic [W-1:0]           count_inc;
  logic [W-1:0]           count_dec;
  logic [XW-1:0]          prod_step;
  logic                   ovf;
  logic [31:0]            r2;
  logic                   ge;
  logic [31:0]            r2_sub;
  logic [K:0]             rnd_full;
  logic [31:0]            rnd;
  logic [31:0]            amag;
  logic [31:0]            angle_new;
  logic [DIFF_W-1:0]      diff;
  logic [DIFF_W-1:0]      diff_abs;
  logic [SPEED_ACC_W-1:0] acc_step;
  logic [30:0]            speed_new;
  logic [31:0]            pos32;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // count magnitude, shared by the index check and the angle path
  assign mag_abs   = count[W-1] ? (~count + W'(1)) : count;
  assign mag_ext   = EW'(mag_abs);
  assign index_hit = mag_ext > EW'(index_threshold);
  assign rev_new   = (mag_ext > EW'(POS_MAX)) ? POS_MAX : mag_ext[30:0];
  assign count_inc = count + W'(1);
  assign count_dec = count - W'(1);

  // shift-add over the bits of 2*pi, msb first
  assign prod_step = {prod[XW-2:0], 1'b0} + (TWO_PI_Q28[cnt[4:0]] ? XW'(mag) : '0);

  // quotient would not fit the angle range: saturate instead of dividing
  assign ovf = prod[XW-1:K] >= (XW - K)'(rev_counts);

  assign r2     = {rem, dvd[K-1]};
  assign ge     = r2 >= {1'b0, rev_counts};
  assign r2_sub = r2 - {1'b0, rev_counts};

  // round half up to FRAC_BITS, then sign and clamp
  assign rnd_full  = {1'b0, dvd} + ROUND_HALF;
  assign rnd       = rnd_full[K:S];
  assign amag      = (sat || rnd[31]) ? 32'h8000_0000 : rnd;
  assign angle_new = neg ? (~amag + 32'd1) : (amag[31] ? {1'b0, POS_MAX} : amag);

  assign diff     = {angle_reg[31], angle_reg} - {prev_angle[31], prev_angle};
  assign diff_abs = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;

  assign acc_step  = {acc[SPEED_ACC_W-2:0], 1'b0}
                   + (sample_rate_hz[cnt[3:0]] ? SPEED_ACC_W'(dm) : '0);
  assign speed_new = (acc > SPEED_ACC_W'(POS_MAX)) ? POS_MAX : acc[30:0];

  generate
    if (W >= 32) begin : g_pos_wide
      assign pos32 = count[31:0];
    end else begin : g_pos_narrow
      assign pos32 = {{(32 - W){count[W-1]}}, count};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      out_valid       <= 1'b0;
      count           <= '0;
      turns           <= '0;
      rev_counts      <= REV_COUNTS_RESET;
      prev_angle      <= '0;
      speed_magnitude <= '0;
      index_threshold <= THRESHOLD_RESET;
      sample_rate_hz  <= SAMPLE_RATE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INDEX_THRESHOLD: index_threshold <= cfg_data;
          REG_SAMPLE_RATE:     sample_rate_hz  <= cfg_data;
          default: ;
        endcase
      end

      // in the final state the load below decides the next beat
      if (out_valid && !out_stall && state != ST_FIN) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            tick  <= (in_data.mode == MODE_TICK);
            state <= ST_PREP;
            case (in_data.mode)
              MODE_A_EDGE: count <= in_data.b_level ? count_dec : count_inc;
              MODE_B_EDGE: count <= in_data.a_level ? count_inc : count_dec;
              MODE_INDEX: begin
                if (index_hit) begin
                  rev_counts <= rev_new;
                  count      <= '0;
                  turns      <= turns + 32'd1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_PREP: begin
          if (rev_counts == '0) begin
            angle_reg <= '0;
            state     <= tick ? ST_DLT : ST_FIN;
          end else begin
            mag   <= mag_abs;
            neg   <= count[W-1];
            prod  <= '0;
            cnt   <= CNT_W'(30);
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod <= prod_step;
          cnt  <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= ST_CHK;
          end
        end
        ST_CHK: begin
          sat <= ovf;
          rem <= prod[K+30:K];
          dvd <= prod[K-1:0];
          cnt <= CNT_W'(K - 1);
          state <= ovf ? ST_ANG : ST_DIV;
        end
        ST_DIV: begin
          rem <= ge ? r2_sub[30:0] : r2[30:0];
          dvd <= {dvd[K-2:0], ge};
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= ST_ANG;
          end
        end
        ST_ANG: begin
          angle_reg <= angle_new;
          state     <= tick ? ST_DLT : ST_FIN;
        end
        ST_DLT: begin
          dm         <= diff_abs;
          prev_angle <= angle_reg;
          acc        <= '0;
          cnt        <= CNT_W'(15);
          state      <= ST_SPD;
        end
        ST_SPD: begin
          acc <= acc_step;
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= ST_SAT;
          end
        end
        ST_SAT: begin
          speed_magnitude <= speed_new;
          state           <= ST_FIN;
        end
        ST_FIN: begin
          // wait for the output register to free up
          if (!out_valid || !out_stall) begin
            out_valid               <= 1'b1;
            out_data.position_count <= pos32;
            out_data.turn_count     <= turns;
            out_data.counts_per_rev <= rev_counts;
            out_data.angle_q16      <= angle_reg;
            out_data.speed_q16      <= speed_magnitude;
            state                   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < rev_counts)
    else $error("divider remainder not below counts per revolution");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FIN)
    else $error("result beat raised outside the final state");

  a_angle_sign: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && !neg && rev_counts != '0) |-> !angle_reg[31])
    else $error("negative angle for a non-negative count");

  a_speed_update: assert property (@(posedge clk) disable iff (rst)
    !$stable(speed_magnitude) |-> ($past(state) == ST_SAT || $past(rst)))
    else $error("speed changed outside a speed tick");
`endif

endmodule

// ----- test/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qeit_pkg::*;

  localparam int FRAC_BITS      = 16;
  localparam int ANGLE_SHIFT    = 28 - FRAC_BITS;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 120;
  localparam int CLIMB_EDGES    = 50;

  class encoder_scoreboard;
    logic        [31:0] edge_count;
    logic        [31:0] turns;
    logic        [30:0] rev_counts;
    logic signed [31:0] prev_angle;
    logic        [30:0] speed_mag;
    logic        [15:0] threshold;
    logic        [15:0] rate;
    out_item_t          expected_results[$];
    int                 mismatches;
    int                 results_seen;
    int                 events_by_mode[4];
    int                 index_taken;
    int                 angle_saturated;
    int                 speed_saturated;
    int                 reg_writes;

    function new();
      edge_count = '0;
      turns      = '0;
      rev_counts = REV_COUNTS_RESET;
      prev_angle = '0;
      speed_mag  = '0;
      threshold  = THRESHOLD_RESET;
      rate       = SAMPLE_RATE_RESET;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] value);
      reg_writes++;
      if (idx == REG_INDEX_THRESHOLD) begin
        threshold = value;
      end else if (idx == REG_SAMPLE_RATE) begin
        rate = value;
      end
    endfunction

    // |count| * 2pi / cpr in Q28, rounded half up to the output format, then signed
    function logic signed [31:0] angle_now();
      logic [31:0]     mag32;
      longint unsigned mag;
      longint unsigned cpr;
      longint unsigned quot;
      longint unsigned rem;
      longint unsigned q28;
      longint unsigned rounded;
      if (rev_counts == 0) return '0;
      mag32 = edge_count[31] ? -edge_count : edge_count;
      mag   = mag32;
      cpr   = rev_counts;
      quot  = mag / cpr;
      rem   = mag % cpr;
      if (quot >= (64'd1 << 28)) begin
        rounded = 64'h8000_0000;
      end else begin
        q28     = quot * TWO_PI_Q28 + (rem * TWO_PI_Q28) / cpr;
        rounded = (q28 + (64'd1 << (ANGLE_SHIFT - 1))) >> ANGLE_SHIFT;
      end
      if (edge_count[31]) begin
        if (rounded > 64'h8000_0000) rounded = 64'h8000_0000;
        return -rounded[31:0];
      end
      if (rounded > POS_MAX) rounded = POS_MAX;
      return rounded[31:0];
    endfunction

    function void track_event(in_item_t it);
      logic        [31:0] mag32;
      logic signed [31:0] angle;
      longint             delta;
      longint unsigned    spd;
      out_item_t          res;
      events_by_mode[it.mode]++;
      case (it.mode)
        MODE_A_EDGE: edge_count = it.b_level ? edge_count - 1 : edge_count + 1;
        MODE_B_EDGE: edge_count = it.a_level ? edge_count + 1 : edge_count - 1;
        MODE_INDEX: begin
          mag32 = edge_count[31] ? -edge_count : edge_count;
          if (mag32 > threshold) begin
            rev_counts = (mag32 > POS_MAX) ? POS_MAX : mag32[30:0];
            edge_count = '0;
            turns      = turns + 1;
            index_taken++;
          end
        end
        default: begin
          angle = angle_now();
          delta = longint'(angle) - longint'(prev_angle);
          if (delta < 0) delta = -delta;
          spd = longint'(delta) * rate;
          if (spd > POS_MAX) begin
            speed_mag = POS_MAX;
            speed_saturated++;
          end else begin
            speed_mag = spd[30:0];
          end
          prev_angle = angle;
        end
      endcase
      res.position_count = edge_count;
      res.turn_count     = turns;
      res.counts_per_rev = rev_counts;
      res.angle_q16      = angle_now();
      res.speed_q16      = speed_mag;
      if (res.angle_q16 == 32'h7FFF_FFFF || res.angle_q16 == 32'h8000_0000) angle_saturated++;
      expected_results.push_back(res);
    endfunction

    function void compare_field(string fname, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: %s expected %h got %h", results_seen, fname, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result %0d arrived with nothing expected", results_seen);
        return;
      end
      want = expected_results.pop_front();
      compare_field("position_count", want.position_count, got.position_count);
      compare_field("turn_count", want.turn_count, got.turn_count);
      compare_field("counts_per_rev", want.counts_per_rev, got.counts_per_rev);
      compare_field("angle_q16", want.angle_q16, got.angle_q16);
      compare_field("speed_q16", want.speed_q16, got.speed_q16);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  in_item_t               in_data;
  logic                   out_valid;
  logic                   out_stall;
  out_item_t              out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [15:0]            cfg_data;

  bit                tx_idle;
  bit                rx_idle;
  bit                hold_request;
  int                quiet_cycles;
  int                sent_items;
  encoder_scoreboard sb;

  quadrature_encoder_index_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.track_event(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // run is stuck if no beat moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", quiet_cycles);
      $display("[quadrature_encoder_index_tracker] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : receiver
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 19) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_item_t ev(mode_t m, logic a, logic b);
    in_item_t it;
    it.mode    = m;
    it.a_level = a;
    it.b_level = b;
    return it;
  endfunction

  // returns at the edge that took the beat, with valid left high
  task automatic send_event(in_item_t it);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sent_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_results.size() != 0);
  endtask

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
  endtask

  task automatic configure(logic [15:0] thr, logic [15:0] rate);
    drain();
    cfg_write(REG_INDEX_THRESHOLD, thr);
    cfg_write(REG_SAMPLE_RATE, rate);
    cfg_valid <= 1'b0;
  endtask

  // well-formed quadrature run in one direction, with the odd speed tick
  task automatic spin(int edges, bit down, int tick_odds);
    for (int i = 0; i < edges; i++) begin
      if ($urandom_range(0, 1))
        send_event(ev(MODE_B_EDGE, !down, 1'($urandom)));
      else
        send_event(ev(MODE_A_EDGE, 1'($urandom), down));
      if ($urandom_range(1, tick_odds) == 1)
        send_event(ev(MODE_TICK, 1'($urandom), 1'($urandom)));
    end
  endtask

  task automatic random_phase(logic [15:0] thr, logic [15:0] rate, int n, bit hold);
    int  stop_at;
    int  pick;
    int  run_max;
    bit  bias;
    configure(thr, rate);
    if (hold) hold_request = 1'b1;
    stop_at = sent_items + n;
    run_max = (thr + 40 > 300) ? 300 : thr + 40;
    bias    = $urandom_range(0, 1);
    while (sent_items < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        spin($urandom_range(1, run_max), ($urandom_range(0, 3) == 0) ? !bias : bias, 10);
        if ($urandom_range(0, 3) != 0)
          send_event(ev(MODE_INDEX, 1'($urandom), 1'($urandom)));
      end else if (pick < 9) begin
        send_event(ev(mode_t'($urandom_range(0, 3)), 1'($urandom), 1'($urandom)));
      end else begin
        send_event(ev(MODE_TICK, 1'($urandom), 1'($urandom)));
      end
    end
  endtask

  initial begin : stimulus
    sb = new();
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    hold_request = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: levels that should be ignored, both edge kinds, rejected index
    send_event(ev(MODE_TICK, 1'b1, 1'b1));
    send_event(ev(MODE_A_EDGE, 1'b1, 1'b0));
    send_event(ev(MODE_A_EDGE, 1'b0, 1'b1));
    send_event(ev(MODE_B_EDGE, 1'b1, 1'b0));
    send_event(ev(MODE_B_EDGE, 1'b0, 1'b1));
    send_event(ev(MODE_INDEX, 1'b1, 1'b0));
    send_event(ev(MODE_A_EDGE, 1'b0, 1'b0));
    send_event(ev(MODE_TICK, 1'b0, 1'b0));
    repeat (3) send_event(ev(MODE_B_EDGE, 1'b0, 1'b1));
    send_event(ev(MODE_TICK, 1'b1, 1'b0));
    send_event(ev(MODE_INDEX, 1'b0, 1'b1));

    // zero threshold, fastest rate: index on a negative count, speed saturation
    configure(16'd0, 16'hFFFF);
    send_event(ev(MODE_A_EDGE, 1'b0, 1'b1));
    send_event(ev(MODE_INDEX, 1'b1, 1'b1));
    send_event(ev(MODE_INDEX, 1'b0, 1'b0));
    send_event(ev(MODE_A_EDGE, 1'b1, 1'b0));
    send_event(ev(MODE_TICK, 1'b0, 1'b1));
    send_event(ev(MODE_TICK, 1'b1, 1'b1));
    send_event(ev(MODE_B_EDGE, 1'b1, 1'b1));

    // top threshold and a zero rate
    configure(16'hFFFF, 16'd0);
    send_event(ev(MODE_TICK, 1'b0, 1'b0));
    send_event(ev(MODE_INDEX, 1'b1, 1'b1));

    random_phase(THRESHOLD_RESET, SAMPLE_RATE_RESET, 200, 1'b0);
    random_phase(16'($urandom_range(0, 40)), 16'hFFFF, 200, 1'b1);
    random_phase(16'($urandom_range(1, 60)), 16'($urandom_range(1, 65535)), 200, 1'b0);
    random_phase(16'hFFFF, 16'd1, 150, 1'b0);
    random_phase(16'd0, 16'($urandom_range(1, 500)), 200, 1'b0);

    tx_idle = 1'b0;
    rx_idle = 1'b0;
    random_phase(16'($urandom_range(0, 30)), 16'd1000, 200, 1'b0);

    // one count per revolution, then wind up many turns and back down
    configure(16'd0, 16'd7);
    send_event(ev(MODE_INDEX, 1'b0, 1'b0));
    send_event(ev(MODE_A_EDGE, 1'b0, 1'b0));
    send_event(ev(MODE_INDEX, 1'b1, 1'b0));
    spin(CLIMB_EDGES, 1'b0, 200);
    send_event(ev(MODE_TICK, 1'b0, 1'b0));
    spin(20, 1'b1, 4);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("events: %0d A edges, %0d B edges, %0d index pulses (%0d taken), %0d ticks, %0d reg writes",
             sb.events_by_mode[MODE_A_EDGE], sb.events_by_mode[MODE_B_EDGE],
             sb.events_by_mode[MODE_INDEX], sb.index_taken, sb.events_by_mode[MODE_TICK],
             sb.reg_writes);
    $display("results checked: %0d, clipped angles %0d, clipped speeds %0d, mismatches %0d",
             sb.results_seen, sb.angle_saturated, sb.speed_saturated, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("[quadrature_encoder_index_tracker] OK");
    end else begin
      $display("[quadrature_encoder_index_tracker] ERROR");
    end
    $finish;
  end

endmodule
